// ===== hdl/scc_pkg.sv =====
`default_nettype none
package scc_pkg;
	localparam int MAX_VERTICES = 32;
	localparam int MAX_DEGREE   = 16;
	localparam int VW   = $clog2(MAX_VERTICES);
	localparam int NW   = $clog2(MAX_VERTICES + 1);
	localparam int DW   = $clog2(MAX_DEGREE + 1);
	localparam int KW   = $clog2(MAX_DEGREE);
	localparam int EAW  = VW + KW;
	localparam int EDEPTH = MAX_VERTICES * MAX_DEGREE;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_RUN    = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BADV  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [5:0] source_vertex;
		logic [5:0] target_vertex;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] vertex;
		logic [4:0] component_index;
		logic       component_end;
		logic       last;
	} result_t;
endpackage
`default_nettype wire

// ===== hdl/strongly_connected_components_top.sv =====
`default_nettype none
// Strongly connected components over a stored directed graph. start is taken
// when busy is low. Add, clear and a rejected command finish without leaving
// the idle state; remove reads each stored edge of the source vertex in turn
// and writes back those that survive; a run takes time set by the graph: the
// first pass reads an edge per edge visit, and the second pass reads each
// edge-list entry checked for each candidate predecessor, since every step
// goes through the single edge memory read port. Results appear one per
// result_valid pulse and must be taken in that cycle; the receiver cannot
// stall them. Writing vertex_count while the engine is idle empties the graph.
module strongly_connected_components_top import scc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        start,
	input  wire cmd_t        cmd,
	output logic             busy,
	output logic             result_valid,
	output result_t          result
);
	logic [NW-1:0] active_n;
	logic          cfg_wr;

	scc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.active_n(active_n),
		.cfg_wr  (cfg_wr)
	);

	scc_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.active_n    (active_n),
		.cfg_wr      (cfg_wr),
		.start       (start),
		.cmd         (cmd),
		.busy        (busy),
		.result_valid(result_valid),
		.result      (result)
	);
endmodule
`default_nettype wire

// ===== hdl/scc_ram.sv =====
`default_nettype none
module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/scc_cfg.sv =====
`default_nettype none
module scc_cfg import scc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic [NW-1:0]    active_n,
	output logic             cfg_wr
);
	logic [5:0] vcount_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {26'd0, vcount_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
		end else if (cfg_wr) begin
			vcount_q <= pwdata[5:0];
		end
	end

	// counts above the vertex limit act as the limit
	assign active_n = (vcount_q > 6'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_q);
endmodule
`default_nettype wire

// ===== hdl/scc_engine.sv =====
`default_nettype none
module scc_engine import scc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [NW-1:0] active_n,
	input  wire logic          cfg_wr,
	input  wire logic          start,
	input  wire cmd_t          cmd,
	output logic               busy,
	output logic               result_valid,
	output result_t            result
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RMRD  = 4'd1;
	localparam logic [3:0] S_RMWR  = 4'd2;
	localparam logic [3:0] S_P1RT  = 4'd3;
	localparam logic [3:0] S_P1TOP = 4'd4;
	localparam logic [3:0] S_P1EDG = 4'd5;
	localparam logic [3:0] S_P2POP = 4'd6;
	localparam logic [3:0] S_P2TOP = 4'd7;
	localparam logic [3:0] S_P2RD  = 4'd8;
	localparam logic [3:0] S_P2CMP = 4'd9;

	logic [3:0]    state_q;
	logic [DW-1:0] deg_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] vis_q;
	logic [VW-1:0] fs_q [MAX_VERTICES];
	logic [VW-1:0] wv_q [MAX_VERTICES];
	logic [NW-1:0] wp_q [MAX_VERTICES];
	logic [NW-1:0] sp0_q, sp1_q, root_q;
	logic [VW-1:0] src_q, dst_q, comp_q;
	logic [DW-1:0] k_q, kept_q;
	logic          pend_v_q, pend_end_q;
	logic [VW-1:0] pend_vx_q, pend_comp_q;
	result_t       res_q;
	logic          res_valid_q;

	logic          ram_we;
	logic [EAW-1:0] ram_waddr, ram_raddr;
	logic [VW-1:0] ram_wdata, ram_rdata;

	logic [VW-1:0] top_i, top_v, wcur, fs_top;
	logic [NW-1:0] top_p;
	logic          bad;
	logic [VW-1:0] in_src, in_dst;

	scc_ram #(.WIDTH(VW), .DEPTH(EDEPTH)) u_edges (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign top_i  = VW'(sp1_q - 1'b1);
	assign top_v  = wv_q[top_i];
	assign top_p  = wp_q[top_i];
	assign wcur   = top_p[VW-1:0];
	assign fs_top = fs_q[VW'(sp0_q - 1'b1)];
	assign in_src = VW'(cmd.source_vertex - 1'b1);
	assign in_dst = VW'(cmd.target_vertex - 1'b1);
	assign bad = (cmd.source_vertex == 6'd0) || (cmd.source_vertex > 6'(active_n))
		|| (cmd.target_vertex == 6'd0) || (cmd.target_vertex > 6'(active_n));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {in_src, deg_q[in_src][KW-1:0]};
		ram_wdata = in_dst;
		ram_raddr = {src_q, k_q[KW-1:0]};
		unique case (state_q)
			S_IDLE: begin
				ram_we = start && (cmd.opcode == OP_ADD) && !bad
					&& (deg_q[in_src] < DW'(MAX_DEGREE));
			end
			S_RMWR: begin
				ram_we    = (ram_rdata != dst_q);
				ram_waddr = {src_q, kept_q[KW-1:0]};
				ram_wdata = ram_rdata;
			end
			S_P1TOP: ram_raddr = {top_v, top_p[KW-1:0]};
			S_P2RD:  ram_raddr = {wcur, k_q[KW-1:0]};
			default: ;
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
			vis_q       <= '0;
			sp0_q       <= '0;
			sp1_q       <= '0;
			for (int i = 0; i < MAX_VERTICES; i++) begin
				deg_q[i] <= '0;
			end
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_wr) begin
						for (int i = 0; i < MAX_VERTICES; i++) begin
							deg_q[i] <= '0;
						end
					end
					if (start) begin
						src_q  <= in_src;
						dst_q  <= in_dst;
						k_q    <= '0;
						kept_q <= '0;
						res_q  <= '{status: ST_OK, vertex: 6'd0, component_index: 5'd0,
							component_end: 1'b0, last: 1'b1};
						unique case (cmd.opcode)
							OP_RUN: begin
								if (active_n == '0) begin
									res_q.status <= ST_EMPTY;
									res_valid_q  <= 1'b1;
								end else begin
									vis_q    <= '0;
									sp0_q    <= '0;
									sp1_q    <= '0;
									root_q   <= '0;
									comp_q   <= '0;
									pend_v_q <= 1'b0;
									state_q  <= S_P1RT;
								end
							end
							OP_CLEAR: begin
								for (int i = 0; i < MAX_VERTICES; i++) begin
									deg_q[i] <= '0;
								end
								res_valid_q <= 1'b1;
							end
							OP_ADD: begin
								res_valid_q <= 1'b1;
								if (bad) begin
									res_q.status <= ST_BADV;
								end else if (deg_q[in_src] >= DW'(MAX_DEGREE)) begin
									res_q.status <= ST_FULL;
								end else begin
									deg_q[in_src] <= deg_q[in_src] + 1'b1;
								end
							end
							OP_REMOVE: begin
								if (bad) begin
									res_q.status <= ST_BADV;
									res_valid_q  <= 1'b1;
								end else begin
									state_q <= S_RMRD;
								end
							end
							default: ;
						endcase
					end
				end
				// compaction: read entry k, write it back at kept when it survives
				S_RMRD: begin
					if (k_q == deg_q[src_q]) begin
						deg_q[src_q] <= kept_q;
						res_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_RMWR;
					end
				end
				S_RMWR: begin
					if (ram_rdata != dst_q) begin
						kept_q <= kept_q + 1'b1;
					end
					k_q     <= k_q + 1'b1;
					state_q <= S_RMRD;
				end
				S_P1RT: begin
					if (root_q == active_n) begin
						vis_q   <= '0;
						state_q <= S_P2POP;
					end else if (vis_q[VW'(root_q)]) begin
						root_q <= root_q + 1'b1;
					end else begin
						vis_q[VW'(root_q)] <= 1'b1;
						wv_q[0] <= VW'(root_q);
						wp_q[0] <= '0;
						sp1_q   <= NW'(1);
						state_q <= S_P1TOP;
					end
				end
				S_P1TOP: begin
					if (sp1_q == '0) begin
						root_q  <= root_q + 1'b1;
						state_q <= S_P1RT;
					end else if (top_p < NW'(deg_q[top_v])) begin
						wp_q[top_i] <= top_p + 1'b1;
						state_q     <= S_P1EDG;
					end else begin
						sp1_q <= sp1_q - 1'b1;
						if (sp0_q < NW'(MAX_VERTICES)) begin
							fs_q[VW'(sp0_q)] <= top_v;
							sp0_q <= sp0_q + 1'b1;
						end
					end
				end
				S_P1EDG: begin
					if ((NW'(ram_rdata) < active_n) && !vis_q[ram_rdata]
							&& (sp1_q < NW'(MAX_VERTICES))) begin
						vis_q[ram_rdata] <= 1'b1;
						wv_q[VW'(sp1_q)] <= ram_rdata;
						wp_q[VW'(sp1_q)] <= '0;
						sp1_q <= sp1_q + 1'b1;
					end
					state_q <= S_P1TOP;
				end
				S_P2POP: begin
					if (sp0_q == '0) begin
						// held-back vertex closes the run
						res_valid_q <= 1'b1;
						res_q <= '{status: ST_OK, vertex: 6'(pend_vx_q) + 6'd1,
							component_index: pend_comp_q, component_end: pend_end_q, last: 1'b1};
						state_q <= S_IDLE;
					end else begin
						sp0_q <= sp0_q - 1'b1;
						if (!vis_q[fs_top]) begin
							vis_q[fs_top] <= 1'b1;
							if (pend_v_q) begin
								res_valid_q <= 1'b1;
								res_q <= '{status: ST_OK, vertex: 6'(pend_vx_q) + 6'd1,
									component_index: pend_comp_q, component_end: pend_end_q,
									last: 1'b0};
							end
							pend_v_q    <= 1'b1;
							pend_vx_q   <= fs_top;
							pend_comp_q <= comp_q;
							pend_end_q  <= 1'b0;
							wv_q[0] <= fs_top;
							wp_q[0] <= '0;
							sp1_q   <= NW'(1);
							state_q <= S_P2TOP;
						end
					end
				end
				S_P2TOP: begin
					if (sp1_q == '0) begin
						pend_end_q <= 1'b1;
						comp_q     <= comp_q + 1'b1;
						state_q    <= S_P2POP;
					end else if (top_p >= active_n) begin
						sp1_q <= sp1_q - 1'b1;
					end else if (vis_q[wcur]) begin
						wp_q[top_i] <= top_p + 1'b1;
					end else begin
						k_q     <= '0;
						state_q <= S_P2RD;
					end
				end
				S_P2RD: begin
					if (k_q == deg_q[wcur]) begin
						wp_q[top_i] <= top_p + 1'b1;
						state_q     <= S_P2TOP;
					end else begin
						state_q <= S_P2CMP;
					end
				end
				S_P2CMP: begin
					if (ram_rdata == top_v) begin
						if (sp1_q < NW'(MAX_VERTICES)) begin
							wp_q[top_i] <= top_p + 1'b1;
							vis_q[wcur] <= 1'b1;
							if (pend_v_q) begin
								res_valid_q <= 1'b1;
								res_q <= '{status: ST_OK, vertex: 6'(pend_vx_q) + 6'd1,
									component_index: pend_comp_q, component_end: pend_end_q,
									last: 1'b0};
							end
							pend_v_q    <= 1'b1;
							pend_vx_q   <= wcur;
							pend_comp_q <= comp_q;
							pend_end_q  <= 1'b0;
							wv_q[VW'(sp1_q)] <= wcur;
							wp_q[VW'(sp1_q)] <= '0;
							sp1_q <= sp1_q + 1'b1;
						end else begin
							sp1_q <= sp1_q - 1'b1;
						end
						state_q <= S_P2TOP;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_P2RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
